// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: label");

`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: label");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: label");

`else

`define ASSERT_IMPLY(label, clk, rst, cond, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== rtl/dfpq_pkg.sv =====
// ----------------------------------------------------------------------------
// dfpq_pkg
// Types and defaults shared by the dual FIFO pending queue.
// ----------------------------------------------------------------------------
package dfpq_pkg;

   localparam int DEPTH_DEFAULT   = 64;
   localparam int TAG_W_DEFAULT   = 32;
   localparam int CMD_W           = 3;
   localparam int STATUS_W        = 2;
   localparam int COUNT_W         = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH         = 3'd0,
      CMD_FRONT        = 3'd1,
      CMD_POP          = 3'd2,
      CMD_CHECK_GET    = 3'd3,
      CMD_CHECK_IGNORE = 3'd4,
      CMD_CHECK_SUCC   = 3'd5,
      CMD_CHECK_PUSH   = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ===== rtl/dfpq_ram.sv =====
// ----------------------------------------------------------------------------
// dfpq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dfpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dual_fifo_pending_queue.sv =====
// ----------------------------------------------------------------------------
// dual_fifo_pending_queue
// Pending-request store of two FIFOs whose online and offline roles swap.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | cmd, elem_tag, elem_has_dma
//   rsp_    | out       | rsp_valid/rsp_stall | out_tag, out_has_dma, dma_req,
//           |           |                     | status, total_count
//
// Push, check-succ and error commands: result registered in the cycle after accept.
// Front, pop and check-get: the RAM read word is registered, then loaded into the output register.
// A new word is taken once the output register is free or drained that cycle
// and no RAM read is pending, so a read holds off the next word until its result is loaded.
// Reset clears pointers, fill counts and roles; RAM contents are left as is.
// ----------------------------------------------------------------------------
module dual_fifo_pending_queue #(
   parameter int FIFO_DEPTH = dfpq_pkg::DEPTH_DEFAULT,
   parameter int TAG_WIDTH  = dfpq_pkg::TAG_W_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dfpq_pkg::CMD_W-1:0]    req_cmd,
   input  logic [TAG_WIDTH-1:0]          req_elem_tag,
   input  logic                          req_elem_has_dma,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [TAG_WIDTH-1:0]          rsp_out_tag,
   output logic                          rsp_out_has_dma,
   output logic                          rsp_dma_req,
   output logic [dfpq_pkg::STATUS_W-1:0] rsp_status,
   output logic [dfpq_pkg::COUNT_W-1:0]  rsp_total_count
);

   import dfpq_pkg::*;

   `include "assert_macros.svh"

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int FW = $clog2(FIFO_DEPTH + 1);
   localparam int EW = $clog2(2 * FIFO_DEPTH + 1);
   localparam int WW = TAG_WIDTH + 1;

   // control state
   logic          online_ff, online_in;
   logic [FW-1:0] fill0_ff, fill0_in, fill1_ff, fill1_in;
   logic [AW-1:0] rptr0_ff, rptr0_in, rptr1_ff, rptr1_in;
   logic [AW-1:0] wptr0_ff, wptr0_in, wptr1_ff, wptr1_in;
   logic [EW-1:0] elem_ff, elem_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_sel_ff, rd_sel_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // result payload
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   logic                 has_dma_ff, has_dma_in;
   logic                 dreq_ff, dreq_in;
   status_type           status_ff, status_in;
   logic [EW-1:0]        count_ff, count_in;

   // RAM ports
   logic          wr_en, wr_sel;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [WW-1:0] wr_word, rd_word0, rd_word1, rd_word;

   logic          accept;
   logic          take_out;
   cmd_type       cmd;

   assign take_out  = rsp_valid_ff && !rsp_stall;
   assign req_stall = rd_pend_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_cmd);
   assign wr_word   = {req_elem_has_dma, req_elem_tag};
   assign rd_word   = rd_sel_ff ? rd_word1 : rd_word0;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      logic          on;
      logic          q;
      logic [FW-1:0] fill_on, fill_off, fill_q;
      logic [AW-1:0] rptr_q, wptr_q;
      logic          do_put, do_take, need_rd, put_dma;
      status_type    st;

      online_in    = online_ff;
      fill0_in     = fill0_ff;
      fill1_in     = fill1_ff;
      rptr0_in     = rptr0_ff;
      rptr1_in     = rptr1_ff;
      wptr0_in     = wptr0_ff;
      wptr1_in     = wptr1_ff;
      elem_in      = elem_ff;
      rd_pend_in   = 1'b0;
      rd_sel_in    = rd_sel_ff;
      rsp_valid_in = rsp_valid_ff && !take_out;
      tag_in       = tag_ff;
      has_dma_in   = has_dma_ff;
      dreq_in      = dreq_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;

      on      = online_ff;
      q       = online_ff;
      do_put  = 1'b0;
      do_take = 1'b0;
      need_rd = 1'b0;
      put_dma = 1'b0;
      st      = ST_OK;

      fill_on  = on ? fill1_ff : fill0_ff;
      fill_off = on ? fill0_ff : fill1_ff;

      unique case (cmd) inside
         CMD_PUSH, CMD_CHECK_PUSH: begin
            if (cmd == CMD_CHECK_PUSH && fill_on == '0) begin
               on       = ~on;
               fill_off = fill_on;
            end
            q       = (fill_off != '0) ? ~on : on;
            do_put  = 1'b1;
            put_dma = req_elem_has_dma;
         end
         CMD_CHECK_IGNORE: begin
            q      = on;
            do_put = 1'b1;
         end
         CMD_FRONT: begin
            q = on;
            if (fill_on != '0) need_rd = 1'b1;
            else st = ST_EMPTY;
         end
         CMD_POP: begin
            q = on;
            if (fill_on != '0) begin
               need_rd = 1'b1;
               do_take = 1'b1;
               if (fill_on == FW'(1) && fill_off != '0) on = ~on;
            end else begin
               st = ST_EMPTY;
            end
         end
         CMD_CHECK_GET: begin
            if (fill_on == '0 && fill_off == '0) begin
               st = ST_EMPTY;
            end else begin
               if (fill_off == '0) on = ~on;
               q       = ~on;
               need_rd = 1'b1;
               do_take = 1'b1;
            end
         end
         CMD_CHECK_SUCC: begin
            if (fill_on == '0) on = ~on;
         end
         default: begin
            st = ST_EMPTY;
         end
      endcase

      fill_q = q ? fill1_ff : fill0_ff;
      rptr_q = q ? rptr1_ff : rptr0_ff;
      wptr_q = q ? wptr1_ff : wptr0_ff;

      if (do_put && fill_q == FW'(FIFO_DEPTH)) begin
         st     = ST_FULL;
         do_put = 1'b0;
      end

      wr_sel  = q;
      wr_addr = wptr_q;
      rd_addr = rptr_q;

      if (accept) begin
         online_in = on;
         rd_sel_in = q;
         if (do_put) begin
            wr_en   = 1'b1;
            elem_in = elem_ff + EW'(1);
            if (q) begin
               fill1_in = fill1_ff + FW'(1);
               wptr1_in = next_ptr(wptr1_ff);
            end else begin
               fill0_in = fill0_ff + FW'(1);
               wptr0_in = next_ptr(wptr0_ff);
            end
         end
         if (do_take) begin
            elem_in = elem_ff - EW'(1);
            if (q) begin
               fill1_in = fill1_ff - FW'(1);
               rptr1_in = next_ptr(rptr1_ff);
            end else begin
               fill0_in = fill0_ff - FW'(1);
               rptr0_in = next_ptr(rptr0_ff);
            end
         end
         status_in = st;
         dreq_in   = do_put && put_dma;
         count_in  = elem_in;
         if (need_rd) begin
            rd_pend_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            tag_in       = do_put ? req_elem_tag : '0;
            has_dma_in   = do_put && req_elem_has_dma;
         end
      end

      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         tag_in       = rd_word[TAG_WIDTH-1:0];
         has_dma_in   = rd_word[TAG_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         online_ff    <= 1'b0;
         fill0_ff     <= '0;
         fill1_ff     <= '0;
         rptr0_ff     <= '0;
         rptr1_ff     <= '0;
         wptr0_ff     <= '0;
         wptr1_ff     <= '0;
         elem_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rd_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         online_ff    <= online_in;
         fill0_ff     <= fill0_in;
         fill1_ff     <= fill1_in;
         rptr0_ff     <= rptr0_in;
         rptr1_ff     <= rptr1_in;
         wptr0_ff     <= wptr0_in;
         wptr1_ff     <= wptr1_in;
         elem_ff      <= elem_in;
         rd_pend_ff   <= rd_pend_in;
         rd_sel_ff    <= rd_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff     <= tag_in;
      has_dma_ff <= has_dma_in;
      dreq_ff    <= dreq_in;
      status_ff  <= status_in;
      count_ff   <= count_in;
   end

   dfpq_ram #(
      .WIDTH (WW),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_zero_ram (
      .clock   (clock),
      .wr_en   (wr_en && !wr_sel),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_word0)
   );

   dfpq_ram #(
      .WIDTH (WW),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_one_ram (
      .clock   (clock),
      .wr_en   (wr_en && wr_sel),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_word1)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_tag     = tag_ff;
   assign rsp_out_has_dma = has_dma_ff;
   assign rsp_dma_req     = dreq_ff;
   assign rsp_status      = status_ff;
   assign rsp_total_count = COUNT_W'(count_ff);

   `ASSERT_NEVER(a_count_sum, clock, reset, elem_ff != (EW'(fill0_ff) + EW'(fill1_ff)))
   `ASSERT_NEXT(a_read_result, clock, reset, rd_pend_ff, rsp_valid_ff && !rd_pend_ff)
   `ASSERT_IMPLY(a_no_write_in_read, clock, reset, rd_pend_ff, !wr_en)
   `ASSERT_IMPLY(a_dma_on_push, clock, reset, rsp_valid_ff && rsp_dma_req,
                 rsp_out_has_dma && status_ff == ST_OK)

endmodule
